/* hw/rtl/prd_pkg.sv */
// Shared types and constants for the perspective ray direction block.
// Depends on nothing; imported by perspective_ray_direction.
package prd_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_FORWARD  = 3'd0,
		REG_LEFT     = 3'd1,
		REG_UP       = 3'd2,
		REG_DISTANCE = 3'd3,
		REG_WIDTH    = 3'd4,
		REG_HEIGHT   = 3'd5
	} cfg_reg_t;

	// The largest normalized magnitude lies in [2^29, 2^30); the others lie below 2^30.
	localparam int NORM_BITS = 30;
	localparam int NORM_TOP  = NORM_BITS - 1;
	// Sum of three squared normalized magnitudes, and the root search width.
	localparam int SUM_BITS  = 2 * NORM_BITS + 2;
	localparam int SQ_W      = SUM_BITS + 1;
	localparam int SQ_STEPS  = SUM_BITS / 2 + 1;
	localparam int ROOT_BITS = NORM_BITS + 1;

	localparam logic [47:0] FORWARD_RST  = 48'h4000_0000_0000;
	localparam logic [47:0] LEFT_RST     = 48'h0000_4000_0000;
	localparam logic [47:0] UP_RST       = 48'h0000_0000_4000;
	localparam logic [15:0] DISTANCE_RST = 16'd2048;
	localparam logic [12:0] WIDTH_RST    = 13'd640;
	localparam logic [12:0] HEIGHT_RST   = 13'd480;

	// Side data that travels with a word through the root and divide stages.
	typedef struct packed {
		logic [2:0][NORM_BITS-1:0] mag;
		logic [2:0]                neg;
		logic                      zero;
	} side_t;

	// One signed 16-bit component of a packed basis vector, x at the top.
	function automatic logic signed [15:0] basis_comp(input logic [47:0] packed_vec,
			input int pos);
		return signed'(packed_vec[16*pos +: 16]);
	endfunction

endpackage

/* hw/rtl/perspective_ray_direction.sv */
// Pinhole camera primary ray direction generator, fully pipelined.
// Depends on prd_pkg for register indexes, reset values and the side-data type.
//
// Usage:
//   A pixel word (pixel_x, pixel_y) is accepted at a rising edge with start high and
//   busy low. busy is always low, so a new pixel may be started in every cycle.
//   Each result appears on dir_x, dir_y, dir_z for one cycle with done high, in the
//   order the pixels were taken.
//   The pipeline runs through the front stages, 32 integer square root steps, a divide
//   setup register, FRAC_BITS + 2 quotient steps of one bit each and an output register.
//   Throughput is one word per cycle. The configuration channel (cfg_valid, cfg_ready,
//   cfg_index, cfg_data) writes the camera basis, plane distance and image size;
//   cfg_ready is always high. Registers must be written only while no pixel is in
//   flight; the block itself does not enforce this.
//   Reset clears every stage valid bit and loads the default camera: identity basis,
//   distance 0.5, 640 by 480 pixels.
//   The receiver cannot stall, so no result is ever held back.
module perspective_ray_direction import prd_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 14
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [COORD_BITS-1:0]  pixel_x,
	input  logic [COORD_BITS-1:0]  pixel_y,
	output logic                   done,
	output logic signed [15:0]     dir_x,
	output logic signed [15:0]     dir_y,
	output logic signed [15:0]     dir_z,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [47:0]            cfg_data
);

	localparam int AW  = ((COORD_BITS + 2) > 14 ? (COORD_BITS + 2) : 14) + 1;
	localparam int VW  = ((AW + 29) > 47 ? (AW + 29) : 47) + 1;
	localparam int LW  = $clog2(VW);
	localparam int QB  = FRAC_BITS + 2;
	localparam int NW  = NORM_BITS + FRAC_BITS + 2;
	localparam int DW  = ROOT_BITS + 1;
	localparam int RW  = DW + 1;
	localparam int QW  = QB > 16 ? QB : 16;

	// Configuration registers.
	logic [47:0] forward_q, left_q, up_q;
	logic [15:0] distance_q;
	logic [12:0] width_q, height_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_q  <= FORWARD_RST;
			left_q     <= LEFT_RST;
			up_q       <= UP_RST;
			distance_q <= DISTANCE_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FORWARD:  forward_q  <= cfg_data;
				REG_LEFT:     left_q     <= cfg_data;
				REG_UP:       up_q       <= cfg_data;
				REG_DISTANCE: distance_q <= cfg_data[15:0];
				REG_WIDTH:    width_q    <= cfg_data[12:0];
				REG_HEIGHT:   height_q   <= cfg_data[12:0];
				default:      ;
			endcase
		end
	end

	// Valid bits of the front stages.
	logic [8:1] vld_s;

	// Stage 1: local vector terms, without the common factor of 4096 on the last two.
	logic [12:0]          h_eff;
	logic [29:0]          a0_d;
	logic signed [AW-1:0] a1_d, a2_d;
	logic [29:0]          a0_s1;
	logic signed [AW-1:0] a1_s1, a2_s1;

	assign h_eff = (height_q == 13'd0) ? 13'd1 : height_q;
	assign a0_d  = {h_eff, 1'b0} * {14'd0, distance_q};
	assign a1_d  = AW'(signed'({1'b0, width_q})) - AW'(signed'({1'b0, pixel_x, 1'b0}));
	assign a2_d  = AW'(signed'({1'b0, h_eff})) - AW'(signed'({1'b0, pixel_y, 1'b0}));

	always_ff @(posedge clk) begin
		a0_s1 <= a0_d;
		a1_s1 <= a1_d;
		a2_s1 <= a2_d;
	end

	// Stage 2: nine products against the basis.
	logic signed [30:0]    a0_ext;
	logic signed [46:0]    pf_d [3];
	logic signed [AW+15:0] pl_d [3];
	logic signed [AW+15:0] pu_d [3];
	logic signed [46:0]    pf_s2 [3];
	logic signed [AW+15:0] pl_s2 [3];
	logic signed [AW+15:0] pu_s2 [3];

	assign a0_ext = signed'({1'b0, a0_s1});

	for (genvar c = 0; c < 3; c++) begin : g_prod
		assign pf_d[c] = a0_ext * basis_comp(forward_q, 2 - c);
		assign pl_d[c] = a1_s1 * basis_comp(left_q, 2 - c);
		assign pu_d[c] = a2_s1 * basis_comp(up_q, 2 - c);
	end

	always_ff @(posedge clk) begin
		pf_s2 <= pf_d;
		pl_s2 <= pl_d;
		pu_s2 <= pu_d;
	end

	// Stage 3: world-space vector.
	logic signed [VW-1:0] v_d  [3];
	logic signed [VW-1:0] v_s3 [3];

	for (genvar c = 0; c < 3; c++) begin : g_vec
		assign v_d[c] = VW'(pf_s2[c]) + ((VW'(pl_s2[c]) + VW'(pu_s2[c])) <<< 12);
	end

	always_ff @(posedge clk) begin
		v_s3 <= v_d;
	end

	// Stage 4: sign and magnitude.
	logic [VW-1:0] mag_s4 [3];
	logic [2:0]    neg_s4;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			neg_s4[c] <= v_s3[c][VW-1];
			mag_s4[c] <= v_s3[c][VW-1] ? VW'(-v_s3[c]) : VW'(v_s3[c]);
		end
	end

	// Stage 5: leading one of the largest magnitude, found on the OR of all three.
	logic [VW-1:0] mag_or;
	logic [LW-1:0] lead_d;
	logic [VW-1:0] mag_s5 [3];
	logic [2:0]    neg_s5;
	logic [LW-1:0] lead_s5;
	logic          zero_s5;

	assign mag_or = mag_s4[0] | mag_s4[1] | mag_s4[2];

	always_comb begin
		lead_d = '0;
		for (int i = 0; i < VW; i++) begin
			if (mag_or[i]) begin
				lead_d = LW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s5  <= mag_s4;
		neg_s5  <= neg_s4;
		lead_s5 <= lead_d;
		zero_s5 <= (mag_or == '0);
	end

	// Stage 6: shift so that the largest magnitude lies in [2^29, 2^30).
	logic [VW-1:0] shifted_d [3];
	side_t         side_s6;

	for (genvar c = 0; c < 3; c++) begin : g_norm
		assign shifted_d[c] = (lead_s5 >= LW'(NORM_TOP)) ?
				(mag_s5[c] >> (lead_s5 - LW'(NORM_TOP))) :
				(mag_s5[c] << (LW'(NORM_TOP) - lead_s5));
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			side_s6.mag[c] <= shifted_d[c][NORM_BITS-1:0];
		end
		side_s6.neg  <= neg_s5;
		side_s6.zero <= zero_s5;
	end

	// Stage 7: squares.
	logic [2*NORM_BITS-1:0] sq_s7 [3];
	side_t                  side_s7;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			sq_s7[c] <= side_s6.mag[c] * side_s6.mag[c];
		end
		side_s7 <= side_s6;
	end

	// Stage 8: sum of squares.
	logic [SUM_BITS-1:0] sum_s8;
	side_t               side_s8;

	always_ff @(posedge clk) begin
		sum_s8  <= SUM_BITS'(sq_s7[0]) + SUM_BITS'(sq_s7[1]) + SUM_BITS'(sq_s7[2]);
		side_s8 <= side_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[7:1], start};
		end
	end

	// Integer square root, one result bit per stage. Index 0 is the stage 8 word.
	logic [SQ_W-1:0] sqs_s  [0:SQ_STEPS];
	logic [SQ_W-1:0] sqr_s  [0:SQ_STEPS];
	side_t           sqd_s  [0:SQ_STEPS];
	logic            sqv_s  [0:SQ_STEPS];

	assign sqs_s[0] = SQ_W'(sum_s8);
	assign sqr_s[0] = '0;
	assign sqd_s[0] = side_s8;
	assign sqv_s[0] = vld_s[8];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [SQ_W-1:0] trial;
		logic            take;

		assign trial = sqr_s[k] + BIT;
		assign take  = (sqs_s[k] >= trial);

		always_ff @(posedge clk) begin
			sqs_s[k+1] <= take ? (sqs_s[k] - trial) : sqs_s[k];
			sqr_s[k+1] <= take ? ((sqr_s[k] >> 1) + BIT) : (sqr_s[k] >> 1);
			sqd_s[k+1] <= sqd_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[k+1] <= 1'b0;
			end else begin
				sqv_s[k+1] <= sqv_s[k];
			end
		end
	end

	// Divide setup: numerator 2*mag*2^FRAC_BITS + n, divisor 2n, per component.
	logic [ROOT_BITS-1:0] root;
	logic [NW-1:0]        num_d [3];

	assign root = sqr_s[SQ_STEPS][ROOT_BITS-1:0];

	for (genvar c = 0; c < 3; c++) begin : g_num
		assign num_d[c] = (NW'(sqd_s[SQ_STEPS].mag[c]) << (FRAC_BITS + 1)) + NW'(root);
	end

	// Restoring division, one quotient bit per stage, three lanes sharing the divisor.
	logic [NW-1:0] dnum_s [0:QB][3];
	logic [RW-1:0] drem_s [0:QB][3];
	logic [QB-1:0] dquo_s [0:QB][3];
	logic [DW-1:0] dden_s [0:QB];
	side_t         dsd_s  [0:QB];
	logic          dv_s   [0:QB];

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			dnum_s[0][c] <= num_d[c];
			drem_s[0][c] <= RW'(num_d[c] >> QB);
			dquo_s[0][c] <= '0;
		end
		dden_s[0] <= {root, 1'b0};
		dsd_s[0]  <= sqd_s[SQ_STEPS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else begin
			dv_s[0] <= sqv_s[SQ_STEPS];
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int QI = QB - 1 - k;
		for (genvar c = 0; c < 3; c++) begin : g_lane
			logic [RW-1:0] shifted;
			logic          take;

			assign shifted = {drem_s[k][c][RW-2:0], dnum_s[k][c][QI]};
			assign take    = (shifted >= RW'(dden_s[k]));

			// Quotient bits below this one are still clear, so the OR sets just this bit.
			always_ff @(posedge clk) begin
				drem_s[k+1][c] <= take ? (shifted - RW'(dden_s[k])) : shifted;
				dquo_s[k+1][c] <= dquo_s[k][c] | (QB'(take) << QI);
				dnum_s[k+1][c] <= dnum_s[k][c];
			end
		end

		always_ff @(posedge clk) begin
			dden_s[k+1] <= dden_s[k];
			dsd_s[k+1]  <= dsd_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= 1'b0;
			end else begin
				dv_s[k+1] <= dv_s[k];
			end
		end
	end

	// Output stage: cap at one, apply the sign, and force zero for a zero vector.
	localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;
	logic [QW-1:0] qcap [3];
	logic [15:0]   res_d [3];
	logic [15:0]   res_q [3];
	logic          done_q;

	for (genvar c = 0; c < 3; c++) begin : g_out
		assign qcap[c]  = (QW'(dquo_s[QB][c]) > ONE) ? ONE : QW'(dquo_s[QB][c]);
		assign res_d[c] = dsd_s[QB].zero ? 16'd0 :
				(dsd_s[QB].neg[c] ? 16'(-qcap[c]) : 16'(qcap[c]));
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_s[QB];
		end
	end

	assign done  = done_q;
	assign dir_x = signed'(res_q[0]);
	assign dir_y = signed'(res_q[1]);
	assign dir_z = signed'(res_q[2]);

endmodule

/* verif/tb_perspective_ray_direction.sv */
// Self-checking testbench for perspective_ray_direction: directed table, then random phases.
// Depends on prd_pkg for register indexes and reset values; predicts every result itself.
module tb_perspective_ray_direction import prd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} dir_t;

	typedef struct {
		bit          is_cfg;
		cfg_reg_t    idx;
		logic [47:0] data;
		logic [11:0] px;
		logic [11:0] py;
		bit          known;
		dir_t        want;
	} row_t;

	logic clk, arst_n, start, busy, done, cfg_valid, cfg_ready;
	logic [11:0] pixel_x, pixel_y;
	logic signed [15:0] dir_x, dir_y, dir_z;
	logic [2:0] cfg_index;
	logic [47:0] cfg_data;

	// Local copy of the camera registers.
	logic [47:0] cam_fwd, cam_left, cam_up;
	logic [15:0] cam_dist;
	logic [12:0] cam_width, cam_height;

	dir_t pending_dirs[$];
	int   fail_count;
	bit   no_idle;

	perspective_ray_direction dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .done(done),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic dir_t trace_dir(logic [11:0] px, logic [11:0] py);
		longint h, a0, a1, a2, v;
		longint unsigned mag[3];
		longint unsigned top, n, q;
		bit neg[3];
		logic [15:0] res[3];
		dir_t d;
		int pos;
		h = (cam_height == 0) ? 1 : longint'(cam_height);
		a0 = 2 * h * longint'(cam_dist);
		a1 = (longint'(cam_width) - 2 * longint'(px)) * 4096;
		a2 = (h - 2 * longint'(py)) * 4096;
		top = 0;
		for (int c = 0; c < 3; c++) begin
			pos = 2 - c;
			v = a0 * longint'(shortint'(cam_fwd[16*pos +: 16]))
				+ a1 * longint'(shortint'(cam_left[16*pos +: 16]))
				+ a2 * longint'(shortint'(cam_up[16*pos +: 16]));
			neg[c] = v < 0;
			mag[c] = neg[c] ? longint'(-v) : v;
			if (mag[c] > top)
				top = mag[c];
		end
		if (top == 0) begin
			d.x = 0; d.y = 0; d.z = 0;
			return d;
		end
		// Bring the largest magnitude into [2^29, 2^30), all three by the same shift.
		while (top >= (64'd1 << 30)) begin
			top >>= 1;
			for (int c = 0; c < 3; c++) mag[c] >>= 1;
		end
		while (top < (64'd1 << 29)) begin
			top <<= 1;
			for (int c = 0; c < 3; c++) mag[c] <<= 1;
		end
		n = root_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
		for (int c = 0; c < 3; c++) begin
			q = ((mag[c] << 15) + n) / (2 * n);
			if (q > 16384)
				q = 16384;
			res[c] = neg[c] ? 16'(64'd0 - q) : 16'(q);
		end
		d.x = res[0]; d.y = res[1]; d.z = res[2];
		return d;
	endfunction

	always @(posedge clk) begin
		dir_t w;
		if (arst_n && done) begin
			if (pending_dirs.size() == 0) begin
				$error("unexpected word: dir_x=%0d dir_y=%0d dir_z=%0d", dir_x, dir_y, dir_z);
				fail_count++;
			end else begin
				w = pending_dirs.pop_front();
				if (dir_x !== w.x) begin
					$error("dir_x expected %0d actual %0d", w.x, dir_x);
					fail_count++;
				end
				if (dir_y !== w.y) begin
					$error("dir_y expected %0d actual %0d", w.y, dir_y);
					fail_count++;
				end
				if (dir_z !== w.z) begin
					$error("dir_z expected %0d actual %0d", w.z, dir_z);
					fail_count++;
				end
			end
		end
	end

	// Inputs are driven at the falling edge; the handshake is sampled at the rising edge.
	task automatic write_reg(cfg_reg_t idx, logic [47:0] data);
		while (!no_idle && $urandom_range(99) < 15)
			@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FORWARD:  cam_fwd = data;
			REG_LEFT:     cam_left = data;
			REG_UP:       cam_up = data;
			REG_DISTANCE: cam_dist = data[15:0];
			REG_WIDTH:    cam_width = data[12:0];
			REG_HEIGHT:   cam_height = data[12:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain;
		start = 1'b0;
		while (pending_dirs.size() != 0)
			@(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit known, dir_t want);
		while (!no_idle && $urandom_range(99) < 15) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		pixel_x = px;
		pixel_y = py;
		do @(posedge clk); while (busy);
		pending_dirs.push_back(known ? want : trace_dir(px, py));
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_comp();
		case ($urandom_range(7))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'h0000;
			3: return 16'h8000;
			4: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] pick_basis();
		return {pick_comp(), pick_comp(), pick_comp()};
	endfunction

	function automatic logic [12:0] pick_size();
		case ($urandom_range(9))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'd4096;
			3: return 13'd8191;
			4: return 13'($urandom_range(64, 1));
			default: return 13'($urandom_range(4096, 1));
		endcase
	endfunction

	function automatic logic [15:0] pick_dist();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic row_t blank_row();
		row_t r;
		r.is_cfg = 1'b0;
		r.idx = REG_FORWARD;
		r.data = '0;
		r.px = '0;
		r.py = '0;
		r.known = 1'b0;
		r.want.x = '0;
		r.want.y = '0;
		r.want.z = '0;
		return r;
	endfunction

	function automatic row_t cfg_row(cfg_reg_t idx, logic [47:0] data);
		row_t r;
		r = blank_row();
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic row_t px_row(int px, int py);
		row_t r;
		r = blank_row();
		r.px = 12'(px);
		r.py = 12'(py);
		return r;
	endfunction

	function automatic row_t known_row(int px, int py, int ex, int ey, int ez);
		row_t r;
		r = px_row(px, py);
		r.known = 1'b1;
		r.want.x = 16'(ex);
		r.want.y = 16'(ey);
		r.want.z = 16'(ez);
		return r;
	endfunction

	initial begin
		row_t plan[$];
		dir_t none;
		int limx, limy;
		logic [11:0] rx, ry;
		none = '{default: '0};
		fail_count = 0;
		no_idle = 1'b0;
		start = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cam_fwd = FORWARD_RST;
		cam_left = LEFT_RST;
		cam_up = UP_RST;
		cam_dist = DISTANCE_RST;
		cam_width = WIDTH_RST;
		cam_height = HEIGHT_RST;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The image center looks straight down the forward axis.
		plan.push_back(known_row(320, 240, 16384, 0, 0));
		plan.push_back(px_row(0, 0));
		plan.push_back(px_row(4095, 4095));
		plan.push_back(px_row(4095, 0));
		plan.push_back(px_row(0, 4095));
		plan.push_back(px_row(639, 479));
		plan.push_back(cfg_row(REG_HEIGHT, 48'd0));
		plan.push_back(px_row(0, 0));
		plan.push_back(px_row(5, 7));
		plan.push_back(cfg_row(REG_HEIGHT, 48'd2));
		plan.push_back(cfg_row(REG_DISTANCE, 48'd0));
		plan.push_back(known_row(320, 1, 0, 0, 0));
		plan.push_back(px_row(321, 0));
		plan.push_back(cfg_row(REG_DISTANCE, 48'hFFFF));
		plan.push_back(cfg_row(REG_WIDTH, 48'd4096));
		plan.push_back(cfg_row(REG_HEIGHT, 48'd4096));
		plan.push_back(px_row(0, 4095));
		plan.push_back(px_row(2048, 2048));
		plan.push_back(cfg_row(REG_FORWARD, 48'h7FFF_8000_1234));
		plan.push_back(cfg_row(REG_LEFT, 48'h8000_8000_8000));
		plan.push_back(cfg_row(REG_UP, 48'h7FFF_0001_FFFF));
		plan.push_back(px_row(17, 4000));
		plan.push_back(px_row(4095, 1));
		plan.push_back(cfg_row(REG_FORWARD, 48'd0));
		plan.push_back(cfg_row(REG_LEFT, 48'd0));
		plan.push_back(cfg_row(REG_UP, 48'd0));
		plan.push_back(known_row(100, 100, 0, 0, 0));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (i == 0 || !plan[i-1].is_cfg)
					drain();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_pixel(plan[i].px, plan[i].py, plan[i].known, plan[i].known ? plan[i].want : none);
			end
		end

		for (int phase = 0; phase < 12; phase++) begin
			drain();
			write_reg(REG_FORWARD, pick_basis());
			write_reg(REG_LEFT, pick_basis());
			write_reg(REG_UP, pick_basis());
			write_reg(REG_DISTANCE, 48'(pick_dist()));
			write_reg(REG_WIDTH, 48'(pick_size()));
			write_reg(REG_HEIGHT, 48'(pick_size()));
			no_idle = (phase == 4);
			limx = (cam_width == 0) ? 0 : ((cam_width > 4096) ? 4095 : cam_width - 1);
			limy = (cam_height == 0) ? 0 : ((cam_height > 4096) ? 4095 : cam_height - 1);
			for (int k = 0; k < 150; k++) begin
				if ($urandom_range(99) < 70) begin
					rx = 12'($urandom_range(limx));
					ry = 12'($urandom_range(limy));
				end else begin
					rx = 12'($urandom);
					ry = 12'($urandom);
				end
				send_pixel(rx, ry, 1'b0, none);
			end
		end
		drain();

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/prd_pkg.sv
hw/rtl/perspective_ray_direction.sv
verif/tb_perspective_ray_direction.sv
